[src/cas_pkg.sv]
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants and types of the circular angle statistics block:
// CORDIC arctangent table, CORDIC gain and the CORDIC request and result words.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

	// cordic datapath
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_W     = 34;
	localparam int STEP_W       = 4;

	// 1/K in Q30
	localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

	// arctangent of 2^-i in turns, 2^32 per turn
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
	};

	// request to the shared cordic unit
	typedef struct packed {
		logic                        start;
		logic                        vec;
		logic signed [CORDIC_W-1:0]  x;
		logic signed [CORDIC_W-1:0]  y;
		logic signed [CORDIC_W-1:0]  z;
	} cordic_req_t;

	// result of the shared cordic unit
	typedef struct packed {
		logic                        done;
		logic signed [CORDIC_W-1:0]  x;
		logic signed [CORDIC_W-1:0]  y;
		logic signed [CORDIC_W-1:0]  z;
	} cordic_rsp_t;

endpackage

`default_nettype wire

[src/cas_ram.sv]
// ----------------------------------------------------------------------------
// cas_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[src/cas_cordic.sv]
// ----------------------------------------------------------------------------
// cas_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_cordic (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cas_pkg::cordic_req_t req,
	output cas_pkg::cordic_rsp_t      rsp
);

	logic signed [cas_pkg::CORDIC_W-1:0] x_q, y_q, z_q;
	logic [cas_pkg::STEP_W-1:0]          step_q;
	logic                                busy_q, vec_q, done_q;
	logic                                cw;
	logic                                last_step;
	logic signed [cas_pkg::CORDIC_W-1:0] xs, ys, at;

	// direction and shifted operands of this step
	always_comb begin
		cw = vec_q ? y_q[cas_pkg::CORDIC_W-1] : !z_q[cas_pkg::CORDIC_W-1];
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = $signed(cas_pkg::CORDIC_W'(cas_pkg::ATAN_TURNS[step_q]));
	end

	assign last_step = (step_q == cas_pkg::STEP_W'(cas_pkg::CORDIC_STEPS - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			vec_q  <= 1'b0;
		end else begin
			done_q <= !req.start && busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				vec_q  <= req.vec;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.x;
			y_q <= req.y;
			z_q <= req.z;
		end else if (busy_q) begin
			if (cw) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;
	assign rsp.z    = z_q;

endmodule

`default_nettype wire

[src/cas_div.sv]
// ----------------------------------------------------------------------------
// cas_div
// Restoring long divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_div #(
	parameter int NW = 64,
	parameter int DW = 38
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    num_q, quo_q;
	logic [DW-1:0]    den_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DW:0]      rem2;
	logic             fit;

	// trial subtraction
	always_comb begin
		rem2 = {rem_q, num_q[NW-1]};
		fit  = rem2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[NW-2:0], fit};
			rem_q <= fit ? DW'(rem2 - {1'b0, den_q}) : DW'(rem2);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

[src/circular_angle_statistics.sv]
// ----------------------------------------------------------------------------
// circular_angle_statistics
// Collects a set of binary angles, accumulates their cosines and sines and,
// on the last word of a set, reports circular mean, order parameter, the
// standard deviation about the mean, sample count and a dropped-sample flag.
//
//   channel  direction  handshake                   payload
//   sample   in         sample_valid/sample_stall   angle, last
//   result   out        result_valid/result_stall   mean_angle, deviation,
//                                                   order_parameter,
//                                                   sample_count, overflow
//
// A stored sample is accepted, rotated in 16 CORDIC steps and added to the sums.
// A sample past capacity is not stored and only sets the dropped-sample flag.
// The last word then runs, as the sums and count call for, a vectoring CORDIC,
// two 64-step divides, one pass over the sample RAM and the square root.
// Reset clears counters, sums and flags; the sample RAM needs no clearing.
// A stalled result waits in its output register; the next set is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_angle_statistics #(
	parameter int MAX_SAMPLES = 64,
	parameter int ANGLE_BITS  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_stall,
	input  wire logic signed [15:0] angle,
	input  wire logic               last,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [15:0]      mean_angle,
	output logic [14:0]             deviation,
	output logic [15:0]             order_parameter,
	output logic [6:0]              sample_count,
	output logic                    overflow
);

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int SW  = 16 + $clog2(MAX_SAMPLES) + 1;
	localparam int DW  = CW + 31;
	localparam int NW  = 64;
	localparam int SQ  = ANGLE_BITS + 1;
	localparam int QW  = 2 * ANGLE_BITS;
	localparam int CRW = cas_pkg::CORDIC_W;
	localparam logic [31:0] MEAN_RND = 32'd1 << (31 - ANGLE_BITS);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_ROT  = 11'b00000000010,
		ST_FIN  = 11'b00000000100,
		ST_VEC  = 11'b00000001000,
		ST_MUL  = 11'b00000010000,
		ST_ODIV = 11'b00000100000,
		ST_DCHK = 11'b00001000000,
		ST_DEV  = 11'b00010000000,
		ST_DDIV = 11'b00100000000,
		ST_SQRT = 11'b01000000000,
		ST_DONE = 11'b10000000000
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q, rd_idx_q;
	logic signed [SW-1:0]    sumc_q, sums_q;
	logic                    drop_q, last_q, flip_q;
	logic [ANGLE_BITS-1:0]   mean_q;
	logic [15:0]             order_q;
	logic [14:0]             dev_q;
	logic [31:0]             xr_q;
	logic [61:0]             p_q;
	logic [NW-1:0]           acc_q;
	logic                    div_go_q;
	logic                    rv_s1, v_s2;
	logic [QW-1:0]           sq_s2;
	logic [2*SQ-1:0]         sv_q, sr_q, sbit_q;

	// output register
	logic                    res_valid_q;
	logic signed [15:0]      res_mean_q;
	logic [14:0]             res_dev_q;
	logic [15:0]             res_order_q;
	logic [6:0]              res_cnt_q;
	logic                    res_ovf_q;

	logic                    acc_in, mem_we, out_free;
	logic                    dev_more, dev_end;
	logic [ANGLE_BITS-1:0]   ang_in, rdata;
	logic [31:0]             z_rot, z_vec;
	logic                    flip_in;
	logic signed [CRW-1:0]   cx_post, cy_post, vx, vy;
	logic signed [15:0]      c15, s15;
	logic signed [ANGLE_BITS-1:0] diff;
	logic signed [QW-1:0]    prod;
	logic [2*SQ-1:0]         s_trial, r_fin;
	logic                    sums_nz;
	logic [NW-1:0]           div_num, div_quo;
	logic [DW-1:0]           div_den;
	logic                    div_done;
	cas_pkg::cordic_req_t    creq;
	cas_pkg::cordic_rsp_t    crsp;

	// Q1.15 rounding with clamp
	function automatic logic signed [15:0] to_q15(input logic signed [CRW-1:0] v);
		logic signed [CRW-1:0] t;
		t = (v + CRW'(16384)) >>> 15;
		if (t > CRW'(32767)) begin
			to_q15 = 16'sd32767;
		end else if (t < -CRW'(32768)) begin
			to_q15 = -16'sd32768;
		end else begin
			to_q15 = 16'(t);
		end
	endfunction

	assign acc_in   = sample_valid && !sample_stall;
	assign mem_we   = acc_in && (cnt_q < CW'(MAX_SAMPLES));
	assign out_free = !res_valid_q || !result_stall;
	assign sums_nz  = (sumc_q != '0) || (sums_q != '0);

	// deviation pass: issue reads, then wait for the stream to drain
	assign dev_more = (state_q == ST_DEV) && (rd_idx_q < cnt_q);
	assign dev_end  = (state_q == ST_DEV) && !(rd_idx_q < cnt_q) && !rv_s1 && !v_s2;

	// cordic operand preparation and post-processing
	always_comb begin
		ang_in  = ANGLE_BITS'($unsigned(angle));
		z_rot   = 32'(ang_in) << (32 - ANGLE_BITS);
		flip_in = z_rot[31] ^ z_rot[30];
		if (flip_in) begin
			z_rot[31] = ~z_rot[31];
		end
		cx_post = flip_q ? -crsp.x : crsp.x;
		cy_post = flip_q ? -crsp.y : crsp.y;
		c15     = to_q15(cx_post);
		s15     = to_q15(cy_post);
		vx      = CRW'(sumc_q) <<< 2;
		vy      = CRW'(sums_q) <<< 2;
		z_vec   = crsp.z[31:0] + MEAN_RND;

		creq       = '0;
		creq.start = 1'b0;
		if (state_q == ST_IDLE) begin
			creq.start = mem_we;
			creq.vec   = 1'b0;
			creq.x     = CRW'(cas_pkg::CORDIC_GAIN);
			creq.y     = '0;
			creq.z     = CRW'($signed(z_rot));
		end else begin
			creq.start = (state_q == ST_FIN) && sums_nz;
			creq.vec   = 1'b1;
			creq.x     = vx[CRW-1] ? -vx : vx;
			creq.y     = vx[CRW-1] ? -vy : vy;
			creq.z     = vx[CRW-1] ? CRW'(33'h080000000) : '0;
		end
	end

	// deviation stream and square root step
	always_comb begin
		diff    = $signed(rdata - mean_q);
		prod    = diff * diff;
		s_trial = sr_q + sbit_q;
		r_fin   = sr_q + ((sv_q > sr_q) ? (2*SQ)'(1) : '0);
	end

	// shared divider operands
	always_comb begin
		if (state_q == ST_ODIV) begin
			div_num = NW'(p_q) + (NW'(cnt_q) << 30);
			div_den = DW'(cnt_q) << 31;
		end else begin
			div_num = acc_q;
			div_den = DW'(cnt_q - 1'b1);
		end
	end

	assign sample_stall = (state_q != ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sumc_q      <= '0;
			sums_q      <= '0;
			drop_q      <= 1'b0;
			div_go_q    <= 1'b0;
			rv_s1       <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
			rd_idx_q    <= '0;
		end else begin
			div_go_q <= (state_q == ST_MUL) || dev_end;
			rv_s1    <= dev_more;
			v_s2     <= rv_s1;
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (mem_we) begin
							state_q <= ST_ROT;
						end else begin
							drop_q <= 1'b1;
							if (last) begin
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_ROT: begin
					if (crsp.done) begin
						sumc_q  <= sumc_q + SW'(c15);
						sums_q  <= sums_q + SW'(s15);
						cnt_q   <= cnt_q + 1'b1;
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					state_q <= sums_nz ? ST_VEC : ST_DCHK;
				end
				ST_VEC: begin
					if (crsp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ODIV;
				end
				ST_ODIV: begin
					if (div_done) begin
						state_q <= ST_DCHK;
					end
				end
				ST_DCHK: begin
					rd_idx_q <= '0;
					state_q  <= (cnt_q > CW'(1)) ? ST_DEV : ST_DONE;
				end
				ST_DEV: begin
					if (dev_more) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (dev_end) begin
						state_q <= ST_DDIV;
					end
				end
				ST_DDIV: begin
					if (div_done) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sbit_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						cnt_q   <= '0;
						sumc_q  <= '0;
						sums_q  <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc_in) begin
			last_q <= last;
			flip_q <= flip_in;
		end
		if (state_q == ST_FIN) begin
			mean_q  <= '0;
			order_q <= '0;
		end
		if (state_q == ST_VEC && crsp.done) begin
			mean_q <= z_vec[31 -: ANGLE_BITS];
			xr_q   <= crsp.x[CRW-1] ? 32'd0 : crsp.x[31:0];
		end
		if (state_q == ST_MUL) begin
			p_q <= xr_q * cas_pkg::CORDIC_GAIN;
		end
		if (state_q == ST_ODIV && div_done) begin
			order_q <= (div_quo[NW-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
		end
		if (state_q == ST_DCHK) begin
			acc_q <= '0;
			dev_q <= '0;
		end
		if (rv_s1) begin
			sq_s2 <= $unsigned(prod);
		end
		if (v_s2) begin
			acc_q <= acc_q + NW'(sq_s2);
		end
		if (state_q == ST_DDIV && div_done) begin
			sv_q   <= div_quo[2*SQ-1:0];
			sr_q   <= '0;
			sbit_q <= (2*SQ)'(1) << (2*SQ - 2);
		end
		if (state_q == ST_SQRT) begin
			if (sbit_q != '0) begin
				if (sv_q >= s_trial) begin
					sv_q <= sv_q - s_trial;
					sr_q <= (sr_q >> 1) + sbit_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end else begin
				dev_q <= (r_fin > (2*SQ)'(32767)) ? 15'h7FFF : r_fin[14:0];
			end
		end
		if (state_q == ST_DONE && out_free) begin
			res_mean_q  <= 16'($signed(mean_q));
			res_dev_q   <= dev_q;
			res_order_q <= order_q;
			res_cnt_q   <= 7'(cnt_q);
			res_ovf_q   <= drop_q;
		end
	end

	cas_ram #(
		.WIDTH (ANGLE_BITS),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (ang_in),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rdata)
	);

	cas_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	cas_div #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign result_valid    = res_valid_q;
	assign mean_angle      = res_mean_q;
	assign deviation       = res_dev_q;
	assign order_parameter = res_order_q;
	assign sample_count    = res_cnt_q;
	assign overflow        = res_ovf_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SAMPLES))
		else $error("sample count beyond capacity");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside of completion");

	a_stream_in_dev: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> state_q == ST_DEV)
		else $error("deviation stream outside its pass");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> (state_q == ST_ODIV || state_q == ST_DDIV))
		else $error("divider started in wrong state");

endmodule

`default_nettype wire
